// ----- hw/rtl/dfscs_pkg.sv -----
package dfscs_pkg;

   // Function codes of a request transaction.
   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   // DataFlash command bytes.
   localparam logic [7:0] CMD_READ       = 8'h03;
   localparam logic [7:0] CMD_MEM_TO_BUF = 8'h53;
   localparam logic [7:0] CMD_BUF_WRITE  = 8'h84;
   localparam logic [7:0] CMD_BUF_TO_MEM = 8'h83;
   localparam logic [7:0] CMD_PAGE_ERASE = 8'h81;

   // Output segments of one job, in the order they are sent.
   // Each code is also the bit position of the segment in a job's flag vector.
   localparam logic [2:0] PH_PRE   = 3'd0;  // commit of the previously open page
   localparam logic [2:0] PH_OPEN  = 3'd1;  // memory-to-buffer frame plus buffer write header
   localparam logic [2:0] PH_DATA  = 3'd2;  // one data byte into the buffer
   localparam logic [2:0] PH_POST  = 3'd3;  // commit of the page just written
   localparam logic [2:0] PH_RHDR  = 3'd4;  // read command and address
   localparam logic [2:0] PH_DUMMY = 3'd5;  // dummy byte that clocks in read data
   localparam logic [2:0] PH_DONE  = 3'd6;  // read beyond the slot end
   localparam logic [2:0] PH_ERASE = 3'd7;  // page erase frames

   localparam int PHASE_COUNT = 8;

   // Upper bound on the erase frames of one clear.
   localparam int MAX_ERASE_FRAMES = 16;

   // Depth of the job queue between front and back.
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] logical_address;
      logic [7:0]  write_byte;
      logic        transfer_last;
   } req_type;

   typedef struct packed {
      logic [7:0] spi_byte;
      logic       frame_start;
      logic       frame_end;
      logic       capture_read;
      logic       read_done;
      logic       run_last;
   } rsp_type;

   // One classified transaction, handed from front to back.
   typedef struct packed {
      logic [PHASE_COUNT-1:0] flags;      // segments to send
      logic [15:0]            pre_page;   // page address to commit first
      logic [15:0]            page;       // page address of write, or first erase page
      logic [15:0]            last_page;  // last erase page address
      logic [15:0]            addr;       // page offset for writes, flash address for reads
      logic [7:0]             data;
      logic                   data_end;   // frame end on the data or dummy byte
   } job_type;

endpackage

// ----- hw/rtl/dfscs_front.sv -----
module dfscs_front import dfscs_pkg::*; #(
   parameter int PAGE_BYTES       = 256,
   parameter int FIRST_SLOT_BYTES = 4096,
   parameter int SLOT_BYTES       = 1024,
   parameter int SLOT_COUNT       = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    csr_wr_en,
   input  logic [2:0] csr_wr_data,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   input  logic    queue_full,
   output logic    push,
   output job_type push_job
);

   localparam logic [15:0] OFF_MASK  = 16'(PAGE_BYTES - 1);
   localparam logic [15:0] PAGE_MASK = ~OFF_MASK;
   localparam logic [16:0] FIRST_SIZE = 17'(FIRST_SLOT_BYTES);
   localparam logic [16:0] OTHER_SIZE = 17'(SLOT_BYTES);

   logic [2:0]  slot_ff, slot_in;
   logic        wfo_ff, wfo_in;
   logic [15:0] open_page_ff, open_page_in;
   logic        rfo_ff, rfo_in;
   logic [15:0] nea_ff, nea_in;

   logic        accept;
   logic [16:0] size;
   logic [15:0] base;
   logic [15:0] fa;
   logic [15:0] fa_page;
   logic [15:0] fa_off;
   logic [15:0] fa_next;
   logic        in_range;
   logic        slot_end;
   logic        off_last;
   logic        cont;
   logic        end_now;
   logic        read_end;
   logic [16:0] slot_top;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Slot geometry and flash address of the request.
   always_comb begin
      if ({2'b00, slot_ff} >= 5'(SLOT_COUNT)) begin
         size = '0;
      end else if (slot_ff == 3'd0) begin
         size = FIRST_SIZE;
      end else begin
         size = OTHER_SIZE;
      end
      base     = 16'({13'd0, slot_ff} * 16'(SLOT_BYTES));
      fa       = base + req_payload.logical_address;
      fa_page  = fa & PAGE_MASK;
      fa_off   = fa & OFF_MASK;
      fa_next  = fa + 16'd1;
      in_range = {1'b0, req_payload.logical_address} < size;
      slot_end = in_range && ({1'b0, req_payload.logical_address} == size - 17'd1);
      off_last = fa_off == OFF_MASK;
      slot_top = {1'b0, base} + size - 17'd1;
   end

   // Classification of an accepted transaction into a job.
   always_comb begin
      push_job     = '0;
      push         = 1'b0;
      wfo_in       = wfo_ff;
      open_page_in = open_page_ff;
      rfo_in       = rfo_ff;
      nea_in       = nea_ff;
      cont         = wfo_ff && in_range && (fa == nea_ff);
      end_now      = req_payload.transfer_last || off_last || slot_end;
      read_end     = req_payload.transfer_last || slot_end;
      push_job.pre_page = open_page_ff;
      push_job.data     = req_payload.write_byte;
      if (accept) begin
         unique case (req_payload.func)
            FUNC_WRITE: begin
               if (wfo_ff && !cont) begin
                  push_job.flags[PH_PRE] = 1'b1;
                  push   = 1'b1;
                  wfo_in = 1'b0;
               end
               if (in_range) begin
                  push   = 1'b1;
                  rfo_in = 1'b0;
                  push_job.page = fa_page;
                  push_job.addr = fa_off;
                  push_job.flags[PH_DATA] = 1'b1;
                  push_job.data_end = end_now;
                  if (!cont) begin
                     push_job.flags[PH_OPEN] = 1'b1;
                     open_page_in = fa_page;
                  end
                  if (end_now) begin
                     push_job.flags[PH_POST] = 1'b1;
                     wfo_in = 1'b0;
                  end else begin
                     wfo_in = 1'b1;
                     nea_in = fa_next;
                  end
               end
            end
            FUNC_READ: begin
               push = 1'b1;
               if (!in_range) begin
                  push_job.flags[PH_DONE] = 1'b1;
               end else begin
                  push_job.flags[PH_PRE]   = wfo_ff;
                  push_job.flags[PH_RHDR]  = !(rfo_ff && (fa == nea_ff));
                  push_job.flags[PH_DUMMY] = 1'b1;
                  push_job.addr     = fa;
                  push_job.data_end = read_end;
                  wfo_in = 1'b0;
                  rfo_in = !read_end;
                  nea_in = fa_next;
               end
            end
            FUNC_CLEAR: begin
               wfo_in = 1'b0;
               rfo_in = 1'b0;
               if (size != '0) begin
                  push = 1'b1;
                  push_job.flags[PH_ERASE] = 1'b1;
                  push_job.page      = base & PAGE_MASK;
                  push_job.last_page = slot_top[15:0] & PAGE_MASK;
               end
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   // Configuration register.
   always_comb begin
      slot_in = csr_wr_en ? csr_wr_data : slot_ff;
   end

   // Frame tracking state.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         wfo_ff       <= 1'b0;
         open_page_ff <= '0;
         rfo_ff       <= 1'b0;
         nea_ff       <= '0;
      end else begin
         slot_ff      <= slot_in;
         wfo_ff       <= wfo_in;
         open_page_ff <= open_page_in;
         rfo_ff       <= rfo_in;
         nea_ff       <= nea_in;
      end
   end

endmodule

// ----- hw/rtl/dfscs_queue.sv -----
module dfscs_queue import dfscs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   output logic    head_valid,
   output job_type head_job,
   input  logic    pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- hw/rtl/dfscs_back.sv -----
module dfscs_back import dfscs_pkg::*; #(
   parameter int PAGE_BYTES = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  job_type head_job,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int ECNT_W = $clog2(MAX_ERASE_FRAMES);

   job_type                job_ff, job_in;
   logic [PHASE_COUNT-1:0] remain_ff, remain_in;
   logic [2:0]             idx_ff, idx_in;
   logic [15:0]            erase_addr_ff, erase_addr_in;
   logic [ECNT_W-1:0]      erase_cnt_ff, erase_cnt_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   busy;
   logic                   adv;
   logic                   load;
   logic [2:0]             cur_phase;
   logic [PHASE_COUNT-1:0] cur_bit;
   logic [PHASE_COUNT-1:0] remain_left;
   logic [2:0]             last_idx;
   logic                   seg_end;
   logic                   erase_final;
   logic                   phase_done;
   logic [7:0]             frame_cmd;
   logic [15:0]            frame_addr;
   logic                   frame_fe;
   rsp_type                byte_out;

   assign busy      = remain_ff != '0;
   assign adv       = busy && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Current segment: lowest pending flag.
   always_comb begin
      cur_phase = PH_PRE;
      for (int i = PHASE_COUNT - 1; i >= 0; i--) begin
         if (remain_ff[i]) begin
            cur_phase = 3'(i);
         end
      end
      cur_bit     = PHASE_COUNT'(1) << cur_phase;
      remain_left = remain_ff & ~cur_bit;
   end

   // Segment length and completion.
   always_comb begin
      unique case (cur_phase) inside
         PH_OPEN:                     last_idx = 3'd7;
         PH_PRE, PH_POST, PH_RHDR,
         PH_ERASE:                    last_idx = 3'd3;
         default:                     last_idx = 3'd0;
      endcase
      seg_end     = idx_ff == last_idx;
      erase_final = (erase_addr_ff == job_ff.last_page) ||
                    (erase_cnt_ff == ECNT_W'(MAX_ERASE_FRAMES - 1));
      phase_done  = seg_end && ((cur_phase != PH_ERASE) || erase_final);
   end

   // Byte generation for the current segment and index.
   always_comb begin
      frame_cmd  = CMD_BUF_TO_MEM;
      frame_addr = job_ff.page;
      frame_fe   = 1'b1;
      unique case (cur_phase)
         PH_PRE: begin
            frame_addr = job_ff.pre_page;
         end
         PH_OPEN: begin
            if (idx_ff[2]) begin
               frame_cmd  = CMD_BUF_WRITE;
               frame_addr = job_ff.addr;
               frame_fe   = 1'b0;
            end else begin
               frame_cmd = CMD_MEM_TO_BUF;
            end
         end
         PH_RHDR: begin
            frame_cmd  = CMD_READ;
            frame_addr = job_ff.addr;
            frame_fe   = 1'b0;
         end
         PH_ERASE: begin
            frame_cmd  = CMD_PAGE_ERASE;
            frame_addr = erase_addr_ff;
         end
         default: begin
            frame_cmd = CMD_BUF_TO_MEM;
         end
      endcase

      byte_out = '0;
      unique case (cur_phase)
         PH_DATA: begin
            byte_out.spi_byte  = job_ff.data;
            byte_out.frame_end = job_ff.data_end;
         end
         PH_DUMMY: begin
            byte_out.capture_read = 1'b1;
            byte_out.frame_end    = job_ff.data_end;
         end
         PH_DONE: begin
            byte_out.read_done = 1'b1;
         end
         default: begin
            // Four-byte frame: command, then a 24-bit address high byte first.
            case (idx_ff[1:0])
               2'd0: begin
                  byte_out.spi_byte    = frame_cmd;
                  byte_out.frame_start = 1'b1;
               end
               2'd1: byte_out.spi_byte = 8'h00;
               2'd2: byte_out.spi_byte = frame_addr[15:8];
               default: begin
                  byte_out.spi_byte  = frame_addr[7:0];
                  byte_out.frame_end = frame_fe;
               end
            endcase
         end
      endcase
      byte_out.run_last = phase_done && (remain_left == '0);
   end

   // Sequencer update and job load.
   always_comb begin
      job_in        = job_ff;
      remain_in     = remain_ff;
      idx_in        = idx_ff;
      erase_addr_in = erase_addr_ff;
      erase_cnt_in  = erase_cnt_ff;
      if (adv) begin
         if (phase_done) begin
            remain_in = remain_left;
            idx_in    = '0;
         end else if (seg_end) begin
            idx_in        = '0;
            erase_addr_in = erase_addr_ff + 16'(PAGE_BYTES);
            erase_cnt_in  = erase_cnt_ff + ECNT_W'(1);
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
      load = head_valid && (!busy || (adv && phase_done && (remain_left == '0)));
      if (load) begin
         job_in        = head_job;
         remain_in     = head_job.flags;
         idx_in        = '0;
         erase_addr_in = head_job.page;
         erase_cnt_in  = '0;
      end
      pop = load;
   end

   // Output register.
   always_comb begin
      rsp_in       = adv ? byte_out : rsp_ff;
      rsp_valid_in = adv || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff    <= '0;
         idx_ff       <= '0;
         erase_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         remain_ff    <= remain_in;
         idx_ff       <= idx_in;
         erase_cnt_ff <= erase_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      erase_addr_ff <= erase_addr_in;
      rsp_ff        <= rsp_in;
   end

endmodule

// ----- hw/rtl/dataflash_slot_command_sequencer_top.sv -----
// Turns host byte requests (write, read, clear of the active slot) into the SPI byte stream for
// a page-buffered DataFlash, one result transaction per SPI byte. The front stage accepts one
// request transaction per cycle while its four-entry job queue has room; the back stage sends
// one byte per cycle while the result channel is not stalled. A request causes one byte for a
// streamed write or read byte, 13 when a write opens and commits a page, four more when a
// write or read first commits another open page, 5 for a read that starts a frame, and four
// per page for a clear (at most 64). The back stage is the rate limit. PAGE_BYTES must be a
// power of two.
module dataflash_slot_command_sequencer_top import dfscs_pkg::*; #(
   parameter int PAGE_BYTES       = 256,
   parameter int FIRST_SLOT_BYTES = 4096,
   parameter int SLOT_BYTES       = 1024,
   parameter int SLOT_COUNT       = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_payload
);

   logic    queue_full;
   logic    push;
   job_type push_job;
   logic    head_valid;
   job_type head_job;
   logic    pop;

   // Request classification and frame tracking.
   dfscs_front #(
      .PAGE_BYTES      (PAGE_BYTES),
      .FIRST_SLOT_BYTES(FIRST_SLOT_BYTES),
      .SLOT_BYTES      (SLOT_BYTES),
      .SLOT_COUNT      (SLOT_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // Job queue between the two stages.
   dfscs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .head_valid(head_valid),
      .head_job  (head_job),
      .pop       (pop)
   );

   // Byte sequencer with output register.
   dfscs_back #(
      .PAGE_BYTES(PAGE_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

// ----- test/spi_stream_checker.sv -----
// Watches the request, result and register channels of the DataFlash command sequencer.
// Each accepted request transaction is turned into the SPI byte transactions it should
// cause, and each accepted result transaction is compared with the oldest of them.
module spi_stream_checker import dfscs_pkg::*; #(
   parameter int PAGE_BYTES       = 256,
   parameter int FIRST_SLOT_BYTES = 4096,
   parameter int SLOT_BYTES       = 1024,
   parameter int SLOT_COUNT       = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_wr_data,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_payload,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_payload,
   output int         mismatch_count,
   output int         bytes_outstanding
);

   localparam int MAX_BYTES_PER_REQ = 64;

   // Shadow of the selected slot and of the frame tracking state.
   logic [2:0]  slot_sel;
   logic        wr_frame_open;
   logic [15:0] wr_page;
   logic        rd_frame_open;
   logic [15:0] resume_addr;

   // SPI byte transactions still owed by the block, oldest first.
   rsp_type spi_bytes_due[$];
   int      req_first;

   // Appends one byte of the transaction being predicted, up to the per-request bound.
   function automatic void push_byte(input int b, input logic fs, input logic fe,
                                     input logic cap, input logic done);
      rsp_type item;
      item.spi_byte     = b[7:0];
      item.frame_start  = fs;
      item.frame_end    = fe;
      item.capture_read = cap;
      item.read_done    = done;
      item.run_last     = 1'b0;
      if (spi_bytes_due.size() - req_first < MAX_BYTES_PER_REQ)
         spi_bytes_due.push_back(item);
   endfunction

   // Three address bytes, high byte first.
   function automatic void addr_bytes(input int a, input logic end_last);
      push_byte(a >> 16, 1'b0, 1'b0, 1'b0, 1'b0);
      push_byte(a >> 8, 1'b0, 1'b0, 1'b0, 1'b0);
      push_byte(a, 1'b0, end_last, 1'b0, 1'b0);
   endfunction

   // A four-byte command frame that names the start of a page.
   function automatic void page_frame(input int cmd, input int pg);
      push_byte(cmd, 1'b1, 1'b0, 1'b0, 1'b0);
      addr_bytes((pg * PAGE_BYTES) & 24'hFFFFFF, 1'b1);
   endfunction

   // Commits the open buffer write frame, if any.
   function automatic void commit_write();
      if (wr_frame_open) begin
         page_frame(CMD_BUF_TO_MEM, wr_page);
         wr_frame_open = 1'b0;
      end
   endfunction

   // Works out the SPI bytes that one request transaction causes.
   function automatic void predict_spi_bytes(input req_type r);
      int   span;
      int   base;
      int   fa;
      int   pg;
      int   off;
      int   next_pg;
      int   end_pg;
      int   frames;
      logic in_range;
      logic slot_end;
      logic fe;
      rsp_type tail;

      req_first = spi_bytes_due.size();
      if (slot_sel >= SLOT_COUNT)
         span = 0;
      else
         span = (slot_sel == 0) ? FIRST_SLOT_BYTES : SLOT_BYTES;
      base     = (slot_sel == 0) ? 0 : int'(slot_sel) * SLOT_BYTES;
      fa       = (base + r.logical_address) & 16'hFFFF;
      pg       = fa / PAGE_BYTES;
      off      = fa % PAGE_BYTES;
      in_range = r.logical_address < span;
      slot_end = in_range && (r.logical_address == span - 1);

      case (r.func)
         FUNC_WRITE: begin
            // A write that does not continue the open frame commits it first.
            if (wr_frame_open && (!in_range || fa != resume_addr))
               commit_write();
            if (in_range) begin
               rd_frame_open = 1'b0;
               if (!wr_frame_open) begin
                  page_frame(CMD_MEM_TO_BUF, pg);
                  push_byte(CMD_BUF_WRITE, 1'b1, 1'b0, 1'b0, 1'b0);
                  push_byte(0, 1'b0, 1'b0, 1'b0, 1'b0);
                  push_byte(off >> 8, 1'b0, 1'b0, 1'b0, 1'b0);
                  push_byte(off, 1'b0, 1'b0, 1'b0, 1'b0);
                  wr_frame_open = 1'b1;
                  wr_page       = pg[15:0];
               end
               if (r.transfer_last || off == PAGE_BYTES - 1 || slot_end) begin
                  push_byte(r.write_byte, 1'b0, 1'b1, 1'b0, 1'b0);
                  commit_write();
               end else begin
                  push_byte(r.write_byte, 1'b0, 1'b0, 1'b0, 1'b0);
                  resume_addr = 16'(fa + 1);
               end
            end
         end
         FUNC_READ: begin
            if (!in_range) begin
               push_byte(0, 1'b0, 1'b0, 1'b0, 1'b1);
            end else begin
               fe = r.transfer_last || slot_end;
               commit_write();
               // Only a read that continues the open read frame skips the header.
               if (!(rd_frame_open && fa == resume_addr)) begin
                  push_byte(CMD_READ, 1'b1, 1'b0, 1'b0, 1'b0);
                  addr_bytes(fa, 1'b0);
               end
               push_byte(0, 1'b0, fe, 1'b1, 1'b0);
               rd_frame_open = !fe;
               resume_addr   = 16'(fa + 1);
            end
         end
         FUNC_CLEAR: begin
            // An open write frame is abandoned, then every page of the slot is erased.
            wr_frame_open = 1'b0;
            rd_frame_open = 1'b0;
            if (span != 0) begin
               next_pg = base / PAGE_BYTES;
               end_pg  = (base + span - 1) / PAGE_BYTES;
               frames  = 0;
               while (next_pg <= end_pg && frames < MAX_BYTES_PER_REQ / 4) begin
                  page_frame(CMD_PAGE_ERASE, next_pg);
                  next_pg++;
                  frames++;
               end
            end
         end
         default: ;
      endcase

      // The last byte of the request carries run_last.
      if (spi_bytes_due.size() > req_first) begin
         tail = spi_bytes_due.pop_back();
         tail.run_last = 1'b1;
         spi_bytes_due.push_back(tail);
      end
   endfunction

   function automatic string show(input rsp_type x);
      return $sformatf("byte=%02h start=%0b end=%0b capture=%0b done=%0b last=%0b",
                       x.spi_byte, x.frame_start, x.frame_end, x.capture_read,
                       x.read_done, x.run_last);
   endfunction

   // Compares one result transaction with the oldest expected byte.
   function automatic void check_spi_byte(input rsp_type got);
      rsp_type want;
      if (spi_bytes_due.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result transaction: %s", show(got));
      end else begin
         want = spi_bytes_due.pop_front();
         if (got.spi_byte !== want.spi_byte || got.frame_start !== want.frame_start ||
             got.frame_end !== want.frame_end || got.capture_read !== want.capture_read ||
             got.read_done !== want.read_done || got.run_last !== want.run_last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result mismatch: expected %s, actual %s", show(want), show(got));
         end
      end
   endfunction

   // Register writes, request predictions and result checks, all at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         slot_sel       = '0;
         wr_frame_open  = 1'b0;
         wr_page        = '0;
         rd_frame_open  = 1'b0;
         resume_addr    = '0;
         mismatch_count = 0;
         spi_bytes_due.delete();
      end else begin
         if (csr_wr_en)
            slot_sel = csr_wr_data;
         if (req_valid && req_ready)
            predict_spi_bytes(req_payload);
         if (rsp_valid && rsp_ready)
            check_spi_byte(rsp_payload);
      end
      bytes_outstanding = spi_bytes_due.size();
   end

endmodule

// ----- test/testbench.sv -----
module testbench;
   import dfscs_pkg::*;

   localparam int         CYCLE_LIMIT  = 600000;
   localparam int         DRAIN_CYCLES = 40;
   localparam int         PAGE         = 256;
   localparam logic [1:0] FUNC_UNUSED  = 2'd3;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [2:0] csr_wr_data;
   logic       req_valid;
   logic       req_ready;
   req_type    req_payload;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_payload;

   int mismatches;
   int outstanding;
   int cycle_count;
   int burst_left;
   bit quiet;
   int items_sent;
   int stall_mode;
   int stall_tick;

   dataflash_slot_command_sequencer_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   spi_stream_checker stream_check (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_payload       (rsp_payload),
      .mismatch_count    (mismatches),
      .bytes_outstanding (outstanding)
   );

   // Clock with a period of 12.
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Result receiver: a stall pattern picked afresh for each stretch of cycles.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         stall_mode = $urandom_range(0, 4);
         stall_tick = 0;
         repeat ($urandom_range(20, 120)) begin
            @(negedge clock);
            case (stall_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= (stall_tick % 3 == 0);
               3:       rsp_ready <= (stall_tick % 16 >= 10);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
            stall_tick++;
         end
      end
   end

   // Sends one request transaction, in bursts with random gaps between them.
   task automatic send_req(input req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = quiet ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_payload <= r;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_one(input logic [1:0] f, input int a, input int b, input bit last_flag);
      req_type r;
      r.func            = f;
      r.logical_address = a[15:0];
      r.write_byte      = b[7:0];
      r.transfer_last   = last_flag;
      send_req(r);
      if (f != FUNC_UNUSED)
         items_sent++;
   endtask

   // A run of consecutive addresses; ending 0 flags the final item, 1 flags none,
   // anything else flags items at random.
   task automatic send_run(input logic [1:0] f, input int start, input int len,
                           input int ending);
      bit last_flag;
      for (int i = 0; i < len; i++) begin
         case (ending)
            0:       last_flag = (i == len - 1);
            1:       last_flag = 1'b0;
            default: last_flag = ($urandom_range(0, 7) == 0);
         endcase
         send_one(f, start + i, $urandom_range(0, 255), last_flag);
      end
   endtask

   // Waits until every expected result has come and the block has settled.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_slot(input logic [2:0] s);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= s;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly well-formed write and read runs in one slot, with clears, broken runs and noise.
   task automatic random_phase(input logic [2:0] s, input int quota);
      int span;
      int kind;
      int start;
      int len;
      int goal;
      int pick;
      logic [1:0] f;
      set_slot(s);
      span  = (s == 0) ? 4096 : 1024;
      quiet = ($urandom_range(0, 3) == 0);
      goal  = items_sent + quota;
      while (items_sent < goal) begin
         kind = $urandom_range(0, 19);
         pick = $urandom_range(0, 9);
         if (pick < 2)
            start = span - $urandom_range(1, 8);
         else if (pick < 4)
            start = $urandom_range(0, span / PAGE - 1) * PAGE + PAGE - $urandom_range(1, 6);
         else
            start = $urandom_range(0, span - 1);
         len = $urandom_range(1, 20);
         f   = $urandom_range(0, 1) ? FUNC_READ : FUNC_WRITE;
         if (kind < 8) begin
            send_run(FUNC_WRITE, start, len, 0);
         end else if (kind < 13) begin
            send_run(FUNC_READ, start, len, 0);
         end else if (kind < 14) begin
            send_one(FUNC_CLEAR, $urandom_range(0, 65535), 0, 1'($urandom_range(0, 1)));
         end else if (kind < 16) begin
            send_run(f, start, len, $urandom_range(1, 2));
         end else if (kind < 17) begin
            // A run that jumps elsewhere part way through.
            send_run(f, start, len / 2 + 1, 1);
            send_run(f, $urandom_range(0, span - 1), len, 0);
         end else begin
            send_one(2'($urandom_range(0, 3)), $urandom_range(0, 65535),
                     $urandom_range(0, 255), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_valid   = 1'b0;
      req_payload = '0;
      burst_left  = 0;
      quiet       = 1'b0;
      items_sent  = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part in slot 0.
      set_slot(3'd0);
      send_one(FUNC_WRITE, 0, 8'h00, 0);
      send_one(FUNC_WRITE, 1, 8'hFF, 0);
      send_one(FUNC_WRITE, 2, 8'hA5, 1);
      // Commit at the last byte of a page.
      send_one(FUNC_WRITE, 16'h00FE, 8'h11, 0);
      send_one(FUNC_WRITE, 16'h00FF, 8'h22, 0);
      // Jump to another address commits the open page first.
      send_one(FUNC_WRITE, 16'h0010, 8'h33, 0);
      send_one(FUNC_WRITE, 16'h0020, 8'h44, 0);
      // Last byte of the slot, then a dropped write with nothing open.
      send_one(FUNC_WRITE, 16'h0FFF, 8'h5A, 0);
      send_one(FUNC_WRITE, 16'h1000, 8'h66, 0);
      // Dropped write while a frame is open commits it.
      send_one(FUNC_WRITE, 16'h0005, 8'h77, 0);
      send_one(FUNC_WRITE, 16'hFFFF, 8'h88, 1);
      // Streamed read, read past the slot end, read at the slot end.
      send_one(FUNC_READ, 0, 0, 0);
      send_one(FUNC_READ, 1, 0, 0);
      send_one(FUNC_READ, 2, 0, 1);
      send_one(FUNC_READ, 16'hFFFF, 8'hFF, 1);
      send_one(FUNC_READ, 16'h0FFF, 0, 0);
      // A read commits an open write frame; a write drops an open read frame.
      send_one(FUNC_WRITE, 3, 8'h99, 0);
      send_one(FUNC_READ, 4, 0, 0);
      send_one(FUNC_WRITE, 5, 8'hC3, 0);
      send_one(FUNC_UNUSED, 16'h1234, 8'h5A, 1);
      // Clear abandons the open write frame and ends a read frame.
      send_one(FUNC_CLEAR, 0, 0, 0);
      send_one(FUNC_READ, 16'h007F, 0, 0);
      send_one(FUNC_CLEAR, 16'hFFFF, 0, 1);
      send_one(FUNC_READ, 16'h0080, 0, 1);

      // Random phases over the slots, both ends of the range among them.
      random_phase(3'd7, 34);
      random_phase(3'd0, 34);
      random_phase(3'd3, 34);
      random_phase(3'd1, 34);
      random_phase(3'd6, 34);
      random_phase(3'd2, 34);
      random_phase(3'd5, 34);
      random_phase(3'd4, 34);
      random_phase(3'd0, 34);
      random_phase(3'd7, 34);

      drain();
      if (mismatches == 0 && outstanding == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/dfscs_pkg.sv
hw/rtl/dfscs_front.sv
hw/rtl/dfscs_queue.sv
hw/rtl/dfscs_back.sv
hw/rtl/dataflash_slot_command_sequencer_top.sv
test/spi_stream_checker.sv
test/testbench.sv
